FILE: rtl/core/plt_pkg.sv
// ============================================================================
// plt_pkg: positional list table package
// Shared widths, operation and status codes, and transaction and cell types.
// ============================================================================
`default_nettype none

package plt_pkg;

  // Number of list entries held by the row of cells
  localparam int unsigned DEPTH  = 64;

  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned FUNC_W = 3;
  localparam int unsigned POS_W  = 7;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned FIDX_W = 6;
  // Width that holds both a position and a count plus one without overflow
  localparam int unsigned CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [FUNC_W-1:0] {
    FN_INS_FRONT = 3'd0,
    FN_INS_END   = 3'd1,
    FN_INS_POS   = 3'd2,
    FN_DEL_FRONT = 3'd3,
    FN_DEL_END   = 3'd4,
    FN_DEL_POS   = 3'd5,
    FN_SEARCH    = 3'd6
  } plt_func_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_BOUNDS   = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } plt_status_e;

  // Input transaction
  typedef struct packed {
    logic [FUNC_W-1:0]       func;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } plt_in_t;

  // Output transaction
  typedef struct packed {
    plt_status_e             status;
    logic signed [VAL_W-1:0] removed_value;
    logic [FIDX_W-1:0]       found_index;
  } plt_out_t;

  // Scan lane entry: a copy of a stored value plus its match flag
  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] data;
  } plt_scan_t;

  // Control broadcast to every cell
  typedef struct packed {
    logic             ins;
    logic             del;
    logic             scan_load;
    logic             scan_shift;
    idx_t             k;
    logic [VAL_W-1:0] value;
    cnt_t             count;
  } plt_cell_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/core/positional_list_table_unit.sv
// ============================================================================
// positional_list_table_unit: bounded ordered list with positional access
// Row of list cells plus a small sequencer for deletes and searches.
// ============================================================================
// Usage:
//   Input channel in_valid_i/in_ready_o carries one operation per transaction
//   (func, position, value). Output channel out_valid_o/out_ready_i returns one
//   result per transaction (status, removed_value, found_index).
//   Inserts update the list in the accept cycle; inserts and every rejected
//   operation present their result in the cycle after acceptance.
//   Deletes and searches snapshot the list into a scan lane that shifts one
//   entry per cycle toward cell 0. A delete at 0-based index k returns once
//   entry k reaches cell 0; a search returns at its first match, or with
//   no match once the last stored entry has reached cell 0.
//   One transaction is in flight at a time; in_ready_o is low while a scan
//   runs or while a result waits that cannot be handed over.
//   Reset empties the list (count zero); stored values are not cleared.
//   When the receiver stalls, the result register holds and the block takes
//   no new transaction until the result is accepted.
// ============================================================================
`default_nettype none

module positional_list_table_unit (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_ready_o,
  input  wire plt_pkg::plt_in_t  in_data_i,
  output      logic              out_valid_o,
  input  wire logic              out_ready_i,
  output      plt_pkg::plt_out_t out_data_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } plt_state_e;

  plt_state_e         state_q, state_d;
  plt_pkg::cnt_t      count_q, count_d;
  plt_pkg::idx_t      step_q, step_d;
  plt_pkg::idx_t      tgt_q, tgt_d;
  logic               is_del_q, is_del_d;
  logic               out_valid_q, out_valid_d;
  plt_pkg::plt_out_t  out_q, out_d;

  logic               acc;
  logic               out_free;
  logic               finish;

  // Decode results
  plt_pkg::plt_out_t  imm_res;
  logic               dec_scan;
  logic               dec_del;
  logic               dec_ins;
  plt_pkg::idx_t      dec_k;

  // Scan results
  plt_pkg::plt_out_t  scan_res;
  logic               scan_done;

  plt_pkg::plt_cell_ctl_t               ctl;
  logic [plt_pkg::VAL_W-1:0]            cell_data [plt_pkg::DEPTH];
  plt_pkg::plt_scan_t                   cell_scan [plt_pkg::DEPTH];

  logic [plt_pkg::CMP_W-1:0] pos_w;
  logic [plt_pkg::CMP_W-1:0] cnt_w;
  logic [plt_pkg::CMP_W-1:0] pos_m1;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign acc        = in_valid_i && in_ready_o;

  assign pos_w  = plt_pkg::CMP_W'(in_data_i.position);
  assign cnt_w  = plt_pkg::CMP_W'(count_q);
  assign pos_m1 = pos_w - plt_pkg::CMP_W'(1);

  // Operation decode against the current count
  always_comb begin
    imm_res  = '{status: plt_pkg::ST_OK, removed_value: '0, found_index: '0};
    dec_scan = 1'b0;
    dec_del  = 1'b0;
    dec_ins  = 1'b0;
    dec_k    = '0;
    case (in_data_i.func)
      plt_pkg::FN_INS_FRONT, plt_pkg::FN_INS_END, plt_pkg::FN_INS_POS: begin
        if (count_q == plt_pkg::cnt_t'(plt_pkg::DEPTH)) begin
          imm_res.status = plt_pkg::ST_FULL;
        end else if (in_data_i.func == plt_pkg::FN_INS_FRONT) begin
          dec_ins = 1'b1;
        end else if (in_data_i.func == plt_pkg::FN_INS_END) begin
          dec_ins = 1'b1;
          dec_k   = plt_pkg::idx_t'(count_q);
        end else if (pos_w != '0 && pos_w <= cnt_w + plt_pkg::CMP_W'(1)) begin
          dec_ins = 1'b1;
          dec_k   = plt_pkg::idx_t'(pos_m1);
        end else begin
          imm_res.status = plt_pkg::ST_BOUNDS;
        end
      end
      plt_pkg::FN_DEL_FRONT, plt_pkg::FN_DEL_END, plt_pkg::FN_DEL_POS: begin
        if (count_q == '0) begin
          imm_res.status = plt_pkg::ST_EMPTY;
        end else if (in_data_i.func == plt_pkg::FN_DEL_FRONT) begin
          dec_del  = 1'b1;
          dec_scan = 1'b1;
        end else if (in_data_i.func == plt_pkg::FN_DEL_END) begin
          dec_del  = 1'b1;
          dec_scan = 1'b1;
          dec_k    = plt_pkg::idx_t'(count_q - plt_pkg::cnt_t'(1));
        end else if (pos_w != '0 && pos_w <= cnt_w) begin
          dec_del  = 1'b1;
          dec_scan = 1'b1;
          dec_k    = plt_pkg::idx_t'(pos_m1);
        end else begin
          imm_res.status = plt_pkg::ST_BOUNDS;
        end
      end
      plt_pkg::FN_SEARCH: begin
        if (count_q == '0) begin
          imm_res.status = plt_pkg::ST_EMPTY;
        end else begin
          dec_scan = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Scan completion: cell 0 holds original entry step_q
  always_comb begin
    scan_res  = '{status: plt_pkg::ST_OK, removed_value: '0, found_index: '0};
    scan_done = 1'b0;
    if (is_del_q) begin
      scan_done              = (step_q == tgt_q);
      scan_res.removed_value = cell_scan[0].data;
    end else if (cell_scan[0].hit) begin
      scan_done            = 1'b1;
      scan_res.found_index = plt_pkg::FIDX_W'(step_q);
    end else if (plt_pkg::cnt_t'(step_q) + plt_pkg::cnt_t'(1) >= count_q) begin
      scan_done       = 1'b1;
      scan_res.status = plt_pkg::ST_NOTFOUND;
    end
  end

  assign finish = (state_q == S_SCAN) && scan_done && out_free;

  // Cell control broadcast
  always_comb begin
    ctl.ins        = acc && dec_ins;
    ctl.del        = acc && dec_del;
    ctl.scan_load  = acc && dec_scan;
    ctl.scan_shift = (state_q == S_SCAN) && !scan_done;
    ctl.k          = dec_k;
    ctl.value      = in_data_i.value;
    ctl.count      = count_q;
  end

  // Sequencer and result register
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    step_d      = step_q;
    tgt_d       = tgt_q;
    is_del_d    = is_del_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          if (dec_ins) begin
            count_d = count_q + plt_pkg::cnt_t'(1);
          end else if (dec_del) begin
            count_d = count_q - plt_pkg::cnt_t'(1);
          end
          if (dec_scan) begin
            state_d  = S_SCAN;
            step_d   = '0;
            tgt_d    = dec_k;
            is_del_d = dec_del;
          end else begin
            out_valid_d = 1'b1;
            out_d       = imm_res;
          end
        end
      end
      S_SCAN: begin
        if (finish) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
          out_d       = scan_res;
        end else if (!scan_done) begin
          step_d = step_q + plt_pkg::idx_t'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      step_q      <= '0;
      tgt_q       <= '0;
      is_del_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      step_q      <= step_d;
      tgt_q       <= tgt_d;
      is_del_q    <= is_del_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Row of list cells
  for (genvar g = 0; g < plt_pkg::DEPTH; g++) begin : g_cell
    logic [plt_pkg::VAL_W-1:0] left_data;
    logic [plt_pkg::VAL_W-1:0] right_data;
    plt_pkg::plt_scan_t        right_scan;

    if (g == 0) begin : g_first
      assign left_data = '0;
    end else begin : g_inner_l
      assign left_data = cell_data[g-1];
    end

    if (g == plt_pkg::DEPTH - 1) begin : g_last
      assign right_data = '0;
      assign right_scan = '0;
    end else begin : g_inner_r
      assign right_data = cell_data[g+1];
      assign right_scan = cell_scan[g+1];
    end

    plt_cell u_cell (
      .clk_i        (clk_i),
      .idx_i        (plt_pkg::idx_t'(g)),
      .ctl_i        (ctl),
      .left_data_i  (left_data),
      .right_data_i (right_data),
      .right_scan_i (right_scan),
      .data_o       (cell_data[g]),
      .scan_o       (cell_scan[g])
    );
  end

  // Checks
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= plt_pkg::cnt_t'(plt_pkg::DEPTH))
    else $error("entry count above depth");

  a_ins_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && dec_ins) |=> (count_q == $past(count_q) + plt_pkg::cnt_t'(1)))
    else $error("insert did not grow the list by one");

  a_search_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && !is_del_q) |-> (count_q != '0))
    else $error("search scan running on an empty list");

endmodule

`default_nettype wire

FILE: rtl/core/plt_cell.sv
// ============================================================================
// plt_cell: one list entry
// Holds one stored value and one scan lane entry. Inserts shift data from the
// left neighbor, deletes and scans shift from the right neighbor.
// ============================================================================
`default_nettype none

module plt_cell (
  input  wire logic                          clk_i,
  input  wire plt_pkg::idx_t                 idx_i,
  input  wire plt_pkg::plt_cell_ctl_t        ctl_i,
  input  wire logic [plt_pkg::VAL_W-1:0]     left_data_i,
  input  wire logic [plt_pkg::VAL_W-1:0]     right_data_i,
  input  wire plt_pkg::plt_scan_t            right_scan_i,
  output      logic [plt_pkg::VAL_W-1:0]     data_o,
  output      plt_pkg::plt_scan_t            scan_o
);

  logic [plt_pkg::VAL_W-1:0] data_q;
  logic [plt_pkg::VAL_W-1:0] data_d;
  plt_pkg::plt_scan_t        scan_q;
  plt_pkg::plt_scan_t        scan_d;

  // Stored entry: open a gap at k on insert, close it on delete
  always_comb begin
    data_d = data_q;
    if (ctl_i.ins) begin
      if (idx_i > ctl_i.k) begin
        data_d = left_data_i;
      end else if (idx_i == ctl_i.k) begin
        data_d = ctl_i.value;
      end
    end else if (ctl_i.del) begin
      if (idx_i >= ctl_i.k) begin
        data_d = right_data_i;
      end
    end
  end

  // Scan lane: snapshot with match flag, then march toward the front
  always_comb begin
    scan_d = scan_q;
    if (ctl_i.scan_load) begin
      scan_d.data = data_q;
      scan_d.hit  = (data_q == ctl_i.value) && (plt_pkg::cnt_t'(idx_i) < ctl_i.count);
    end else if (ctl_i.scan_shift) begin
      scan_d = right_scan_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    scan_q <= scan_d;
  end

  assign data_o = data_q;
  assign scan_o = scan_q;

endmodule

`default_nettype wire
